[hw/rtl/pscl_pkg.sv]
// Shared types, constants and helpers for the packet stream gain field clearer.
package pscl_pkg;

    localparam int MAX_LENGTH_BYTES_DEF = 4;
    localparam int LEN_W                = 28;
    localparam int PATCH_W              = 4;

    localparam logic [PATCH_W-1:0] PATCH_LEN    = 4'd9;
    localparam logic [LEN_W-1:0]   RG_TOTAL_LEN = 28'd12;
    localparam logic [7:0]         KEY_R        = 8'h52;
    localparam logic [7:0]         KEY_G        = 8'h47;
    localparam logic [7:0]         PATCH_VER    = 8'h01;

    typedef enum logic [2:0] {
        PH_MAGIC = 3'd0,
        PH_KEY0  = 3'd1,
        PH_KEY1  = 3'd2,
        PH_LEN   = 3'd3,
        PH_SKIP  = 3'd4,
        PH_PATCH = 3'd5,
        PH_DONE  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        OC_PATCHED   = 2'd0,
        OC_NOTFOUND  = 2'd1,
        OC_BADMAGIC  = 2'd2,
        OC_MALFORMED = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [7:0] data;
        outcome_t   outcome;
    } result_t;

    // Container magic "MPCK", one byte per position.
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = 8'h4D;
            2'd1:    b = 8'h50;
            2'd2:    b = 8'h43;
            default: b = 8'h4B;
        endcase
        return b;
    endfunction

endpackage

[hw/rtl/pscl_parse.sv]
// Packet walker: parser state registers and the per-beat next-state logic.
module pscl_parse #(
    parameter int MAX_LENGTH_BYTES = pscl_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output pscl_pkg::result_t res
);

    localparam int CNT_W = $clog2(MAX_LENGTH_BYTES + 1);
    localparam int LEN_W = pscl_pkg::LEN_W;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_LENGTH_BYTES - 1);

    pscl_pkg::phase_t         phase_reg, phase_next;
    pscl_pkg::outcome_t       result_reg, result_next;
    logic [1:0]               magic_idx_reg, magic_idx_next;
    logic [7:0]               key_reg, key_next;
    logic [LEN_W-1:0]         len_sum_reg, len_sum_next;
    logic [CNT_W-1:0]         len_cnt_reg, len_cnt_next;
    logic [LEN_W-1:0]         skip_reg, skip_next;
    logic [pscl_pkg::PATCH_W-1:0] patch_reg, patch_next;

    logic [LEN_W-1:0] len_cat;
    logic [LEN_W-1:0] hdr_len;

    assign len_cat = {len_sum_reg[LEN_W-8:0], in_byte[6:0]};
    // Header length is the two key bytes plus the length bytes taken so far.
    assign hdr_len = LEN_W'(len_cnt_reg) + LEN_W'(3);

    always_comb
    begin
        phase_next     = phase_reg;
        result_next    = result_reg;
        magic_idx_next = magic_idx_reg;
        key_next       = key_reg;
        len_sum_next   = len_sum_reg;
        len_cnt_next   = len_cnt_reg;
        skip_next      = skip_reg;
        patch_next     = patch_reg;
        res.data       = in_byte;
        res.outcome    = pscl_pkg::OC_PATCHED;

        unique case (phase_reg)
            pscl_pkg::PH_MAGIC:
            begin
                if (in_byte != pscl_pkg::magic_byte(magic_idx_reg))
                begin
                    result_next = pscl_pkg::OC_BADMAGIC;
                    phase_next  = pscl_pkg::PH_DONE;
                end
                else if (magic_idx_reg == 2'd3)
                begin
                    magic_idx_next = 2'd0;
                    phase_next     = pscl_pkg::PH_KEY0;
                end
                else
                begin
                    magic_idx_next = magic_idx_reg + 2'd1;
                end
            end
            pscl_pkg::PH_KEY0:
            begin
                key_next   = in_byte;
                phase_next = pscl_pkg::PH_KEY1;
            end
            pscl_pkg::PH_KEY1:
            begin
                // From here on the key register only flags an "RG" key.
                key_next     = {7'd0, (key_reg == pscl_pkg::KEY_R) &&
                                      (in_byte == pscl_pkg::KEY_G)};
                len_sum_next = '0;
                len_cnt_next = '0;
                phase_next   = pscl_pkg::PH_LEN;
            end
            pscl_pkg::PH_LEN:
            begin
                len_sum_next = len_cat;
                if (in_byte[7] && (len_cnt_reg < CNT_LAST))
                begin
                    len_cnt_next = len_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    len_cnt_next = '0;
                    if ((key_reg == 8'd1) && (len_cat == pscl_pkg::RG_TOTAL_LEN))
                    begin
                        result_next = pscl_pkg::OC_PATCHED;
                        patch_next  = pscl_pkg::PATCH_LEN;
                        phase_next  = pscl_pkg::PH_PATCH;
                    end
                    else if (len_cat < hdr_len)
                    begin
                        result_next = pscl_pkg::OC_MALFORMED;
                        phase_next  = pscl_pkg::PH_DONE;
                    end
                    else
                    begin
                        skip_next  = len_cat - hdr_len;
                        phase_next = (len_cat == hdr_len) ? pscl_pkg::PH_KEY0
                                                          : pscl_pkg::PH_SKIP;
                    end
                end
            end
            pscl_pkg::PH_SKIP:
            begin
                skip_next = (skip_reg != '0) ? skip_reg - LEN_W'(1) : skip_reg;
                if (skip_next == '0)
                begin
                    phase_next = pscl_pkg::PH_KEY0;
                end
            end
            pscl_pkg::PH_PATCH:
            begin
                res.data   = (patch_reg == pscl_pkg::PATCH_LEN) ? pscl_pkg::PATCH_VER
                                                                : 8'h00;
                patch_next = (patch_reg != '0) ? patch_reg - 4'd1 : patch_reg;
                if (patch_next == '0)
                begin
                    phase_next = pscl_pkg::PH_DONE;
                end
            end
            default:
            begin
                phase_next = pscl_pkg::PH_DONE;
            end
        endcase

        // The last beat reports the outcome and rearms the parser for the next file.
        if (in_last)
        begin
            res.outcome    = (phase_next == pscl_pkg::PH_MAGIC) ? pscl_pkg::OC_BADMAGIC
                                                                : result_next;
            phase_next     = pscl_pkg::PH_MAGIC;
            result_next    = pscl_pkg::OC_NOTFOUND;
            magic_idx_next = '0;
            key_next       = '0;
            len_sum_next   = '0;
            len_cnt_next   = '0;
            skip_next      = '0;
            patch_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pscl_pkg::PH_MAGIC;
            result_reg    <= pscl_pkg::OC_NOTFOUND;
            magic_idx_reg <= '0;
            key_reg       <= '0;
            len_sum_reg   <= '0;
            len_cnt_reg   <= '0;
            skip_reg      <= '0;
            patch_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            result_reg    <= result_next;
            magic_idx_reg <= magic_idx_next;
            key_reg       <= key_next;
            len_sum_reg   <= len_sum_next;
            len_cnt_reg   <= len_cnt_next;
            skip_reg      <= skip_next;
            patch_reg     <= patch_next;
        end
    end

endmodule

[hw/rtl/packet_stream_gain_field_clearer.sv]
// Top level: input register, packet walker and result register.
//
// Streams the bytes of one container file, one beat per byte, checks the "MPCK"
// magic, walks the packets and replaces the nine bytes after the length field of
// the first "RG" packet of total length 12 with version 1 and eight zeros; all
// other bytes pass through unchanged. The beat flagged last carries the outcome
// (patched, not found, bad magic, malformed) and the next beat starts a new file.
// One byte is taken per clock cycle while the output is not stalled. A byte
// accepted into the input register moves into the result register when the
// output is free, and an output stall holds it in the input register. The rate
// is set by the parser state update, which is computed combinationally between
// those two registers. The input register also serves as a skid stage, so one
// new byte can still be accepted while a finished result waits.
module packet_stream_gain_field_clearer #(
    parameter int MAX_LENGTH_BYTES = pscl_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic [1:0] outcome
);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic [1:0] outcome_reg;

    logic              out_free;
    logic              advance;
    logic              in_take;
    pscl_pkg::result_t res;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    pscl_parse #(
        .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .in_byte (s1_byte_reg),
        .in_last (s1_last_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= in_last;
        end
        if (advance)
        begin
            out_byte_reg <= res.data;
            out_last_reg <= s1_last_reg;
            outcome_reg  <= res.outcome;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign outcome   = outcome_reg;

endmodule
